FILE: sv/rse_pkg.sv
// shared types, constants and operation codes for the instruction executor
package rse_pkg;

  localparam int MEM_ADDR_BITS_DEF = 16;
  localparam int XLEN              = 32;
  localparam int REG_IDX_W         = 5;
  localparam int NUM_REGS          = 32;
  localparam int FUNC_W            = 5;
  localparam int LANES             = 4;
  localparam int LANE_W            = 8;
  localparam int OUT_ADDR_W        = 16;
  localparam int IN_DATA_W         = 56;
  localparam int OUT_DATA_W        = 88;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_AND  = 5'd2,
    OP_OR   = 5'd3,
    OP_XOR  = 5'd4,
    OP_NOR  = 5'd5,
    OP_SLT  = 5'd6,
    OP_SLL  = 5'd7,
    OP_SRA  = 5'd8,
    OP_ADDI = 5'd9,
    OP_ANDI = 5'd10,
    OP_ORI  = 5'd11,
    OP_XORI = 5'd12,
    OP_SLTI = 5'd13,
    OP_LW   = 5'd14,
    OP_LB   = 5'd15,
    OP_SW   = 5'd16,
    OP_SB   = 5'd17,
    OP_LUI  = 5'd18
  } func_t;

  typedef struct packed {
    logic                 wreg;
    logic [REG_IDX_W-1:0] rd;
    logic [XLEN-1:0]      val;
    logic                 wmem;
    logic                 is_lw;
    logic                 is_lb;
    logic                 is_word;
    logic [XLEN-1:0]      data;
  } exec_t;

endpackage

FILE: sv/rse_ram.sv
// generic single-write, single-read ram with registered read data
module rse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/rse_alu.sv
// execute logic: alu, compare, shifts and effective address of one instruction
module rse_alu #(
  parameter int ADDR_W = rse_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic [rse_pkg::FUNC_W-1:0]    func,
  input  logic [rse_pkg::REG_IDX_W-1:0] rd,
  input  logic [rse_pkg::XLEN-1:0]      a,
  input  logic [rse_pkg::XLEN-1:0]      b,
  input  logic [rse_pkg::XLEN-1:0]      imm,
  output rse_pkg::exec_t                ex,
  output logic [ADDR_W-1:0]             addr
);

  logic [rse_pkg::XLEN-1:0] sum;
  logic [rse_pkg::XLEN-1:0] val;
  logic [rse_pkg::XLEN-1:0] data;
  logic                     wreg;
  logic                     wmem;
  logic                     is_lw;
  logic                     is_lb;
  logic                     is_word;

  always_comb begin
    sum     = a + imm;
    val     = '0;
    data    = '0;
    wreg    = 1'b1;
    wmem    = 1'b0;
    is_lw   = 1'b0;
    is_lb   = 1'b0;
    is_word = 1'b0;
    unique case (rse_pkg::func_t'(func))
      rse_pkg::OP_ADD:  val = a + b;
      rse_pkg::OP_SUB:  val = a - b;
      rse_pkg::OP_AND:  val = a & b;
      rse_pkg::OP_OR:   val = a | b;
      rse_pkg::OP_XOR:  val = a ^ b;
      rse_pkg::OP_NOR:  val = ~(a | b);
      rse_pkg::OP_SLT:  val = {31'b0, $signed(a) < $signed(b)};
      rse_pkg::OP_SLL:  val = a << b[4:0];
      rse_pkg::OP_SRA:  val = $unsigned($signed(a) >>> b[4:0]);
      rse_pkg::OP_ADDI: val = sum;
      rse_pkg::OP_ANDI: val = a & imm;
      rse_pkg::OP_ORI:  val = a | imm;
      rse_pkg::OP_XORI: val = a ^ imm;
      rse_pkg::OP_SLTI: val = {31'b0, $signed(a) < $signed(imm)};
      rse_pkg::OP_LW:   is_lw = 1'b1;
      rse_pkg::OP_LB:   is_lb = 1'b1;
      rse_pkg::OP_SW: begin
        wreg    = 1'b0;
        wmem    = 1'b1;
        is_word = 1'b1;
        data    = b;
      end
      rse_pkg::OP_SB: begin
        wreg = 1'b0;
        wmem = 1'b1;
        data = {24'b0, b[7:0]};
      end
      rse_pkg::OP_LUI:  val = {imm[19:0], 12'b0};
      default:          wreg = 1'b0;
    endcase

    ex.wreg    = wreg && (rd != '0);
    ex.rd      = ex.wreg ? rd : '0;
    ex.val     = ex.wreg ? val : '0;
    ex.wmem    = wmem;
    ex.is_lw   = is_lw;
    ex.is_lb   = is_lb;
    ex.is_word = is_word;
    ex.data    = data;
  end

  assign addr = sum[ADDR_W-1:0];

endmodule

FILE: sv/rse_dmem.sv
// byte-addressed data memory in four byte lanes, with clearing pass after reset
module rse_dmem #(
  parameter int ADDR_W = rse_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic                     is_word,
  input  logic [ADDR_W-1:0]        addr,
  input  logic [rse_pkg::XLEN-1:0] wdata,
  input  logic [1:0]               rd_off,
  output logic [rse_pkg::XLEN-1:0] rd_word,
  output logic                     busy
);

  localparam int ROW_W = ADDR_W - 2;
  localparam int DEPTH = 2 ** ROW_W;

  logic                        clr_busy_r;
  logic [ROW_W-1:0]            clr_row_r;
  logic [rse_pkg::LANE_W-1:0]  lane_q [rse_pkg::LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clr_busy_r) begin
      clr_row_r <= clr_row_r + ROW_W'(1);
      if (clr_row_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign busy = clr_busy_r;

  for (genvar l = 0; l < rse_pkg::LANES; l++) begin : g_lane
    logic [1:0]                 byte_sel;
    logic [ROW_W-1:0]           row_sel;
    logic                       lane_we;
    logic [ROW_W-1:0]           lane_waddr;
    logic [rse_pkg::LANE_W-1:0] lane_wdata;

    always_comb begin
      byte_sel = 2'(l) - addr[1:0];
      row_sel  = addr[ADDR_W-1:2] + ROW_W'(2'(l) < addr[1:0]);
      if (clr_busy_r) begin
        lane_we    = 1'b1;
        lane_waddr = clr_row_r;
        lane_wdata = '0;
      end else begin
        lane_we    = wr_en && (is_word || (byte_sel == 2'd0));
        lane_waddr = row_sel;
        lane_wdata = wdata[{byte_sel, 3'b000} +: rse_pkg::LANE_W];
      end
    end

    rse_ram #(
      .WIDTH (rse_pkg::LANE_W),
      .DEPTH (DEPTH)
    ) u_lane (
      .clk   (clk),
      .we    (lane_we),
      .waddr (lane_waddr),
      .wdata (lane_wdata),
      .re    (rd_en),
      .raddr (row_sel),
      .rdata (lane_q[l])
    );
  end

  always_comb begin
    for (int k = 0; k < rse_pkg::LANES; k++) begin
      rd_word[8*k +: 8] = lane_q[2'(rd_off + 2'(k))];
    end
  end

endmodule

FILE: sv/riscv_subset_executor.sv
// top level: instruction stream in, register/memory write report out
// Executes one decoded instruction per transaction and returns one result transaction
// per instruction, in order. Throughput is one instruction per cycle while the output is
// not stalled, loads and unaligned word accesses included; out_tvalid rises when the
// result reaches the output register (the register file is read at acceptance, then
// execute and memory access, then writeback into the output register). Results of
// earlier instructions are forwarded, so dependent instructions may follow back to back.
// After reset the data memory is cleared one 32-bit row per cycle across its four byte
// lanes; in_tready is low until its 2**(MEM_ADDR_BITS-2) rows (16384 by default) are clear.
module riscv_subset_executor #(
  parameter int MEM_ADDR_BITS = rse_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // func[4:0], dest_or_source_reg[9:5], first_source_reg[14:10],
  // second_source_reg[19:15], immediate[51:20]
  input  logic [rse_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // reg_written[0], written_reg[5:1], written_value[37:6], mem_written[38],
  // mem_address[54:39], mem_data[86:55]
  output logic [rse_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int XW = rse_pkg::XLEN;
  localparam int RW = rse_pkg::REG_IDX_W;

  logic [rse_pkg::FUNC_W-1:0] in_func;
  logic [RW-1:0]              in_rd;
  logic [RW-1:0]              in_rs1;
  logic [RW-1:0]              in_rs2;
  logic [RW-1:0]              in_rb_sel;
  logic [XW-1:0]              in_imm;
  logic                       in_acc;

  logic                       s1_v_r;
  logic [rse_pkg::FUNC_W-1:0] s1_func_r;
  logic [RW-1:0]              s1_rd_r;
  logic [RW-1:0]              s1_ra_r;
  logic [RW-1:0]              s1_rb_r;
  logic [XW-1:0]              s1_imm_r;
  logic                       s1_va_r;
  logic                       s1_vb_r;
  logic [XW-1:0]              rf_a_q;
  logic [XW-1:0]              rf_b_q;
  logic [XW-1:0]              op_a;
  logic [XW-1:0]              op_b;
  rse_pkg::exec_t             s1_ex;
  logic [MEM_ADDR_BITS-1:0]   s1_addr;

  logic                       s2_v_r;
  rse_pkg::exec_t             s2_ex_r;
  logic [MEM_ADDR_BITS-1:0]   s2_addr_r;
  logic [XW-1:0]              ld_word;
  logic [XW-1:0]              s2_final;
  logic [XW-1:0]              s2_addr_ext;
  logic [rse_pkg::OUT_DATA_W-1:0] s2_pack;

  logic                       out_v_r;
  logic [rse_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [rse_pkg::NUM_REGS-1:0] rf_valid_r;
  logic                       wb_v_r;
  logic [RW-1:0]              wb_idx_r;
  logic [XW-1:0]              wb_val_r;
  logic                       wb_we;

  logic                       out_en;
  logic                       s2_ready;
  logic                       s1_ready;
  logic                       s1_go;
  logic                       s2_go;
  logic                       mem_busy;

  assign in_func = in_tdata[4:0];
  assign in_rd   = in_tdata[9:5];
  assign in_rs1  = in_tdata[14:10];
  assign in_rs2  = in_tdata[19:15];
  assign in_imm  = in_tdata[51:20];

  assign in_rb_sel = (in_func == rse_pkg::OP_SW || in_func == rse_pkg::OP_SB) ? in_rd : in_rs2;

  // pipeline flow control
  assign out_en    = !out_v_r || out_tready;
  assign s2_ready  = !s2_v_r || out_en;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign s1_go     = s1_v_r && s2_ready;
  assign s2_go     = s2_v_r && out_en;
  assign in_tready = s1_ready && !mem_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign wb_we     = s2_go && s2_ex_r.wreg;

  rse_ram #(
    .WIDTH (XW),
    .DEPTH (rse_pkg::NUM_REGS)
  ) u_rf_a (
    .clk   (clk),
    .we    (wb_we),
    .waddr (s2_ex_r.rd),
    .wdata (s2_final),
    .re    (in_acc),
    .raddr (in_rs1),
    .rdata (rf_a_q)
  );

  rse_ram #(
    .WIDTH (XW),
    .DEPTH (rse_pkg::NUM_REGS)
  ) u_rf_b (
    .clk   (clk),
    .we    (wb_we),
    .waddr (s2_ex_r.rd),
    .wdata (s2_final),
    .re    (in_acc),
    .raddr (in_rb_sel),
    .rdata (rf_b_q)
  );

  // operand forwarding: memory-access stage result, then last writeback, then register file
  function automatic logic [XW-1:0] fwd(
    input logic [RW-1:0] idx,
    input logic [XW-1:0] ram_q,
    input logic          ram_v,
    input logic          s2_hit_v,
    input logic [RW-1:0] s2_idx,
    input logic [XW-1:0] s2_val,
    input logic          wb_v,
    input logic [RW-1:0] wb_idx,
    input logic [XW-1:0] wb_val
  );
    logic [XW-1:0] res;
    if (idx == '0) begin
      res = '0;
    end else if (s2_hit_v && s2_idx == idx) begin
      res = s2_val;
    end else if (wb_v && wb_idx == idx) begin
      res = wb_val;
    end else if (ram_v) begin
      res = ram_q;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  assign op_a = fwd(s1_ra_r, rf_a_q, s1_va_r, s2_v_r && s2_ex_r.wreg, s2_ex_r.rd, s2_final,
                    wb_v_r, wb_idx_r, wb_val_r);
  assign op_b = fwd(s1_rb_r, rf_b_q, s1_vb_r, s2_v_r && s2_ex_r.wreg, s2_ex_r.rd, s2_final,
                    wb_v_r, wb_idx_r, wb_val_r);

  rse_alu #(
    .ADDR_W (MEM_ADDR_BITS)
  ) u_alu (
    .func (s1_func_r),
    .rd   (s1_rd_r),
    .a    (op_a),
    .b    (op_b),
    .imm  (s1_imm_r),
    .ex   (s1_ex),
    .addr (s1_addr)
  );

  rse_dmem #(
    .ADDR_W (MEM_ADDR_BITS)
  ) u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_go && (s1_ex.is_lw || s1_ex.is_lb)),
    .wr_en   (s1_go && s1_ex.wmem),
    .is_word (s1_ex.is_word),
    .addr    (s1_addr),
    .wdata   (s1_ex.data),
    .rd_off  (s2_addr_r[1:0]),
    .rd_word (ld_word),
    .busy    (mem_busy)
  );

  always_comb begin
    if (!s2_ex_r.wreg) begin
      s2_final = '0;
    end else if (s2_ex_r.is_lw) begin
      s2_final = ld_word;
    end else if (s2_ex_r.is_lb) begin
      s2_final = {{24{ld_word[7]}}, ld_word[7:0]};
    end else begin
      s2_final = s2_ex_r.val;
    end
    s2_addr_ext = XW'(s2_addr_r);
    s2_pack = {1'b0,
               s2_ex_r.wmem ? s2_ex_r.data : {XW{1'b0}},
               s2_ex_r.wmem ? s2_addr_ext[rse_pkg::OUT_ADDR_W-1:0]
                            : {rse_pkg::OUT_ADDR_W{1'b0}},
               s2_ex_r.wmem,
               s2_final,
               s2_ex_r.rd,
               s2_ex_r.wreg};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      rf_valid_r <= '0;
      wb_v_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (wb_we) begin
        rf_valid_r[s2_ex_r.rd] <= 1'b1;
        wb_v_r                 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_func;
      s1_rd_r   <= in_rd;
      s1_ra_r   <= in_rs1;
      s1_rb_r   <= in_rb_sel;
      s1_imm_r  <= in_imm;
      s1_va_r   <= rf_valid_r[in_rs1];
      s1_vb_r   <= rf_valid_r[in_rb_sel];
    end
    if (s1_go) begin
      s2_ex_r   <= s1_ex;
      s2_addr_r <= s1_addr;
    end
    if (s2_go) begin
      out_data_r <= s2_pack;
    end
    if (wb_we) begin
      wb_idx_r <= s2_ex_r.rd;
      wb_val_r <= s2_final;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: tb/riscv_subset_executor_test.sv
// testbench for the instruction executor: stream stimulus, predicted results, field checks
`timescale 1ns / 100ps

module riscv_subset_executor_test;

  typedef struct packed {
    logic [31:0] imm;
    logic [4:0]  rs2;
    logic [4:0]  rs1;
    logic [4:0]  rd;
    logic [4:0]  func;
  } instr_t;

  typedef struct {
    logic        reg_written;
    logic [4:0]  written_reg;
    logic [31:0] written_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [31:0] mem_data;
  } exec_result_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [rse_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [rse_pkg::OUT_DATA_W-1:0] out_tdata;

  logic [31:0]  reg_model [0:31];
  logic [7:0]   mem_model [0:65535];
  exec_result_t result_q[$];

  int   error_count    = 0;
  int   burst_left     = 0;
  bit   no_gaps        = 1'b0;
  int   rx_hold_cycles = 0;
  logic [7:0] rx_cycle = '0;

  riscv_subset_executor #(
    .MEM_ADDR_BITS(16)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic instr_t make_instr(logic [4:0] func, logic [4:0] rd, logic [4:0] rs1,
                                        logic [4:0] rs2, logic [31:0] imm);
    instr_t ins;
    ins.func = func;
    ins.rd   = rd;
    ins.rs1  = rs1;
    ins.rs2  = rs2;
    ins.imm  = imm;
    return ins;
  endfunction

  // executes one instruction on the shadow state and returns its report
  function automatic exec_result_t predict_exec(instr_t ins);
    exec_result_t res;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] val;
    logic [31:0] data;
    logic [15:0] addr;
    logic        wreg;
    logic        wmem;
    a    = (ins.rs1 == 5'd0) ? 32'd0 : reg_model[ins.rs1];
    b    = (ins.rs2 == 5'd0) ? 32'd0 : reg_model[ins.rs2];
    addr = 16'(a + ins.imm);
    val  = '0;
    data = '0;
    wreg = 1'b1;
    wmem = 1'b0;
    case (ins.func)
      rse_pkg::OP_ADD:  val = a + b;
      rse_pkg::OP_SUB:  val = a - b;
      rse_pkg::OP_AND:  val = a & b;
      rse_pkg::OP_OR:   val = a | b;
      rse_pkg::OP_XOR:  val = a ^ b;
      rse_pkg::OP_NOR:  val = ~(a | b);
      rse_pkg::OP_SLT:  val = {31'd0, $signed(a) < $signed(b)};
      rse_pkg::OP_SLL:  val = a << b[4:0];
      rse_pkg::OP_SRA:  val = $unsigned($signed(a) >>> b[4:0]);
      rse_pkg::OP_ADDI: val = a + ins.imm;
      rse_pkg::OP_ANDI: val = a & ins.imm;
      rse_pkg::OP_ORI:  val = a | ins.imm;
      rse_pkg::OP_XORI: val = a ^ ins.imm;
      rse_pkg::OP_SLTI: val = {31'd0, $signed(a) < $signed(ins.imm)};
      rse_pkg::OP_LW: begin
        val = {mem_model[16'(addr + 16'd3)], mem_model[16'(addr + 16'd2)],
               mem_model[16'(addr + 16'd1)], mem_model[addr]};
      end
      rse_pkg::OP_LB:   val = {{24{mem_model[addr][7]}}, mem_model[addr]};
      rse_pkg::OP_SW: begin
        wreg = 1'b0;
        wmem = 1'b1;
        data = (ins.rd == 5'd0) ? 32'd0 : reg_model[ins.rd];
        mem_model[addr]                = data[7:0];
        mem_model[16'(addr + 16'd1)]   = data[15:8];
        mem_model[16'(addr + 16'd2)]   = data[23:16];
        mem_model[16'(addr + 16'd3)]   = data[31:24];
      end
      rse_pkg::OP_SB: begin
        wreg = 1'b0;
        wmem = 1'b1;
        data = (ins.rd == 5'd0) ? 32'd0 : {24'd0, reg_model[ins.rd][7:0]};
        mem_model[addr] = data[7:0];
      end
      rse_pkg::OP_LUI:  val = ins.imm << 12;
      default: wreg = 1'b0;
    endcase
    if (wreg && ins.rd != 5'd0) begin
      reg_model[ins.rd] = val;
    end else begin
      wreg = 1'b0;
      val  = '0;
    end
    res.reg_written   = wreg;
    res.written_reg   = wreg ? ins.rd : 5'd0;
    res.written_value = val;
    res.mem_written   = wmem;
    res.mem_address   = wmem ? addr : 16'd0;
    res.mem_data      = data;
    return res;
  endfunction

  // most memory accesses target a 16-byte window so loads see earlier stores
  function automatic instr_t make_random_instr(logic [15:0] window);
    instr_t      ins;
    int          pick;
    logic [15:0] target;
    ins.func = 5'($urandom_range(rse_pkg::OP_ADD, rse_pkg::OP_SRA));
    ins.rd   = 5'($urandom);
    ins.rs1  = 5'($urandom);
    ins.rs2  = 5'($urandom);
    ins.imm  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      ins.func = 5'($urandom_range(19, 31));
    end else if (pick < 56 && pick >= 36) begin
      ins.func = ($urandom_range(0, 5) == 0) ? 5'(rse_pkg::OP_LUI)
                 : 5'($urandom_range(rse_pkg::OP_ADDI, rse_pkg::OP_SLTI));
      if ($urandom_range(0, 1) == 1) ins.imm = 32'($urandom_range(0, 4095)) - 32'd2048;
    end else if (pick >= 56) begin
      ins.func = 5'($urandom_range(rse_pkg::OP_LW, rse_pkg::OP_SB));
      target = window + 16'($urandom_range(0, 15));
      if ($urandom_range(0, 9) != 0) begin
        ins.imm = {16'($urandom), target}
                  - {16'd0, ((ins.rs1 == 5'd0) ? 16'd0 : reg_model[ins.rs1][15:0])};
      end
    end
    return ins;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    error_count++;
  endtask

  task automatic check_result(logic [rse_pkg::OUT_DATA_W-1:0] word);
    exec_result_t want;
    if (result_q.size() == 0) begin
      report_mismatch("unexpected result transaction", word[37:6], 32'd0);
      return;
    end
    want = result_q.pop_front();
    if (word[0] !== want.reg_written)
      report_mismatch("reg_written", 32'(word[0]), 32'(want.reg_written));
    if (word[5:1] !== want.written_reg)
      report_mismatch("written_reg", 32'(word[5:1]), 32'(want.written_reg));
    if (word[37:6] !== want.written_value)
      report_mismatch("written_value", word[37:6], want.written_value);
    if (word[38] !== want.mem_written)
      report_mismatch("mem_written", 32'(word[38]), 32'(want.mem_written));
    if (word[54:39] !== want.mem_address)
      report_mismatch("mem_address", 32'(word[54:39]), 32'(want.mem_address));
    if (word[86:55] !== want.mem_data)
      report_mismatch("mem_data", word[86:55], want.mem_data);
  endtask

  task automatic send_instr(input instr_t ins);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, ins.imm, ins.rs2, ins.rs1, ins.rd, ins.func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    result_q.push_back(predict_exec(ins));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_drained();
    while (result_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // receiver: long hold-off when requested, otherwise a rotating stall pattern
  always @(posedge clk) begin
    if (out_tvalid && out_tready) check_result(out_tdata);
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      case (rx_cycle[7:6])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ($urandom_range(0, 3) != 0);
        2'd2: out_tready <= ($urandom_range(0, 9) < 3);
        default: out_tready <= rx_cycle[1];
      endcase
    end
  end

  task automatic test_alu_extremes();
    send_instr(make_instr(rse_pkg::OP_LUI,  5'd1,  5'd0, 5'd0, 32'h0008_0000));
    send_instr(make_instr(rse_pkg::OP_LUI,  5'd2,  5'd0, 5'd0, 32'hffff_ffff));
    send_instr(make_instr(rse_pkg::OP_ADDI, 5'd2,  5'd2, 5'd0, 32'h0000_0fff));
    send_instr(make_instr(rse_pkg::OP_ADDI, 5'd3,  5'd0, 5'd0, 32'h7fff_ffff));
    send_instr(make_instr(rse_pkg::OP_ADD,  5'd4,  5'd3, 5'd3, 32'd0));
    send_instr(make_instr(rse_pkg::OP_SUB,  5'd5,  5'd0, 5'd1, 32'd0));
    send_instr(make_instr(rse_pkg::OP_AND,  5'd6,  5'd2, 5'd3, 32'd0));
    send_instr(make_instr(rse_pkg::OP_OR,   5'd7,  5'd1, 5'd3, 32'd0));
    send_instr(make_instr(rse_pkg::OP_XOR,  5'd8,  5'd2, 5'd3, 32'd0));
    send_instr(make_instr(rse_pkg::OP_NOR,  5'd9,  5'd0, 5'd0, 32'd0));
    send_instr(make_instr(rse_pkg::OP_SLT,  5'd10, 5'd1, 5'd3, 32'd0));
    send_instr(make_instr(rse_pkg::OP_SLT,  5'd11, 5'd3, 5'd1, 32'd0));
    send_instr(make_instr(rse_pkg::OP_SLL,  5'd12, 5'd2, 5'd3, 32'd0));
    send_instr(make_instr(rse_pkg::OP_SRA,  5'd13, 5'd1, 5'd3, 32'd0));
    send_instr(make_instr(rse_pkg::OP_SRA,  5'd14, 5'd1, 5'd0, 32'd0));
    send_instr(make_instr(rse_pkg::OP_ANDI, 5'd15, 5'd2, 5'd0, 32'h8000_0000));
    send_instr(make_instr(rse_pkg::OP_ORI,  5'd16, 5'd0, 5'd0, 32'h0f0f_0f0f));
    send_instr(make_instr(rse_pkg::OP_XORI, 5'd17, 5'd3, 5'd0, 32'hffff_ffff));
    send_instr(make_instr(rse_pkg::OP_SLTI, 5'd18, 5'd1, 5'd0, 32'h7fff_ffff));
    send_instr(make_instr(rse_pkg::OP_ADD,  5'd0,  5'd3, 5'd3, 32'd0));
    send_instr(make_instr(5'd19,            5'd5,  5'd1, 5'd2, 32'h1234_5678));
    send_instr(make_instr(5'd31,            5'd31, 5'd31, 5'd31, 32'hffff_ffff));
  endtask

  task automatic test_memory_wrap();
    send_instr(make_instr(rse_pkg::OP_SW, 5'd2,  5'd0, 5'd0, 32'h0000_fffe));
    send_instr(make_instr(rse_pkg::OP_LW, 5'd20, 5'd0, 5'd0, 32'h0000_fffe));
    send_instr(make_instr(rse_pkg::OP_LB, 5'd21, 5'd0, 5'd0, 32'hffff_ffff));
    send_instr(make_instr(rse_pkg::OP_SB, 5'd3,  5'd0, 5'd0, 32'h0000_0005));
    send_instr(make_instr(rse_pkg::OP_LB, 5'd22, 5'd0, 5'd0, 32'h0000_0005));
    send_instr(make_instr(rse_pkg::OP_SW, 5'd1,  5'd3, 5'd0, 32'h0000_0001));
    send_instr(make_instr(rse_pkg::OP_LW, 5'd23, 5'd0, 5'd0, 32'h0000_ffff));
  endtask

  task automatic test_dependent_chain();
    instr_t     ins;
    logic [4:0] prev_rd;
    prev_rd = 5'd3;
    no_gaps = 1'b1;
    repeat (40) begin
      ins = make_random_instr(16'h0100);
      if (ins.func < rse_pkg::OP_LW) ins.rs1 = prev_rd;
      ins.rs2 = prev_rd;
      if (ins.func == rse_pkg::OP_SW || ins.func == rse_pkg::OP_SB) ins.rd = prev_rd;
      else if (ins.rd != 5'd0) prev_rd = ins.rd;
      send_instr(ins);
    end
    no_gaps = 1'b0;
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random_program();
    logic [15:0] window;
    window = 16'h0000;
    for (int i = 0; i < 470; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: window = 16'h0000;
          1: window = 16'hfff8;
          default: window = 16'($urandom);
        endcase
      end
      send_instr(make_random_instr(window));
    end
  endtask

  task automatic test_output_stall();
    rx_hold_cycles = 300;
    no_gaps = 1'b1;
    repeat (40) send_instr(make_random_instr(16'h0040));
    no_gaps = 1'b0;
  endtask

  initial begin
    foreach (reg_model[i]) reg_model[i] = '0;
    foreach (mem_model[i]) mem_model[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_alu_extremes();
    test_memory_wrap();
    test_dependent_chain();
    test_random_program();
    test_output_stall();
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_600_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
